@@ rtl/core/cbpe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbpe_pkg: shared types and constants of the cubic Bezier point evaluator
// Coordinate and parameter types, register indexes, control point bundle.
// ----------------------------------------------------------------------------
package cbpe_pkg;

	localparam int COORD_W = 16;   // Q1.15 signed coordinate
	localparam int T_W     = 16;   // Q0.16 unsigned curve parameter
	localparam int NUM_PTS = 4;
	localparam int REG_IDX_W  = 4;  // wide enough to see writes past the last register
	localparam int REG_DATA_W = COORD_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic        [T_W-1:0]     tparam_t;
	typedef logic        [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_P0_X = 4'd0;
	localparam reg_idx_t REG_P0_Y = 4'd1;
	localparam reg_idx_t REG_P1_X = 4'd2;
	localparam reg_idx_t REG_P1_Y = 4'd3;
	localparam reg_idx_t REG_P2_X = 4'd4;
	localparam reg_idx_t REG_P2_Y = 4'd5;
	localparam reg_idx_t REG_P3_X = 4'd6;
	localparam reg_idx_t REG_P3_Y = 4'd7;

	// control points, one coordinate array per axis
	typedef struct packed {
		coord_t [NUM_PTS-1:0] x;
		coord_t [NUM_PTS-1:0] y;
	} ctrl_pts_t;

endpackage
`default_nettype wire

@@ rtl/core/cbpe_chan_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbpe_chan_if: valid/ready channels of the cubic Bezier point evaluator
// Parameter channel (param_t) and point channel (point_x, point_y).
// ----------------------------------------------------------------------------
interface cbpe_param_if import cbpe_pkg::*; ();
	logic    valid;
	logic    ready;
	tparam_t param_t;

	modport source (output valid, output param_t, input ready);
	modport sink   (input valid, input param_t, output ready);
endinterface

interface cbpe_point_if import cbpe_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink   (input valid, input point_x, input point_y, output ready);
endinterface
`default_nettype wire

@@ rtl/core/cubic_bezier_point_eval.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval: 2D cubic Bezier point evaluator, de Casteljau
// Three-stage pipeline, one interpolation level per stage and axis.
// ----------------------------------------------------------------------------
// Usage:
//   Load the four control points through the write port (cfg_we, cfg_idx,
//   cfg_data; index 0..7 = p0_x, p0_y, ... p3_y, Q1.15). Load them only while
//   no beat is in flight. Writes to index 8 and up are dropped.
//   Each beat on param_ch carries t in Q0.16; each beat on point_ch carries
//   the curve point (point_x, point_y) in Q1.15, one result per input beat,
//   in order.
//   An accepted parameter beat passes through stage 1, stage 2 and the output
//   register before it shows as a valid point beat. While the receiver takes
//   beats, throughput is one beat per cycle: each stage holds one multiply level
//   (six, four, two 17x17 products) and the last stage is the output register.
//   When the receiver stalls, the output register holds its beat and the
//   stages behind it keep filling bubbles; param_ch.ready drops only once
//   all three stages hold a beat.
//   Reset clears the control points to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval import cbpe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  reg_idx_t              cfg_idx,
	input  logic [REG_DATA_W-1:0] cfg_data,
	cbpe_param_if.sink            param_ch,
	cbpe_point_if.source          point_ch
);

	ctrl_pts_t pts;

	cbpe_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pts      (pts)
	);

	// Stage control: a stage may load when it is empty or its beat moves on.
	logic valid_s1, valid_s2, valid_s3;
	logic adv_s1, adv_s2, adv_s3;

	assign adv_s3 = !valid_s3 || point_ch.ready;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign param_ch.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= param_ch.valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	// Level 1: three lerps per axis between neighboring control points.
	coord_t [2:0] lx1, ly1;
	coord_t [2:0] x_s1, y_s1;
	tparam_t      t_s1;

	for (genvar i = 0; i < 3; i++) begin : g_lvl1
		cbpe_lerp u_lx (.a(pts.x[i]), .b(pts.x[i+1]), .t(param_ch.param_t), .y(lx1[i]));
		cbpe_lerp u_ly (.a(pts.y[i]), .b(pts.y[i+1]), .t(param_ch.param_t), .y(ly1[i]));
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			x_s1 <= lx1;
			y_s1 <= ly1;
			t_s1 <= param_ch.param_t;
		end
	end

	// Level 2: two lerps per axis.
	coord_t [1:0] lx2, ly2;
	coord_t [1:0] x_s2, y_s2;
	tparam_t      t_s2;

	for (genvar i = 0; i < 2; i++) begin : g_lvl2
		cbpe_lerp u_lx (.a(x_s1[i]), .b(x_s1[i+1]), .t(t_s1), .y(lx2[i]));
		cbpe_lerp u_ly (.a(y_s1[i]), .b(y_s1[i+1]), .t(t_s1), .y(ly2[i]));
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			x_s2 <= lx2;
			y_s2 <= ly2;
			t_s2 <= t_s1;
		end
	end

	// Level 3: final lerp per axis into the output register.
	coord_t lx3, ly3;
	coord_t x_s3, y_s3;

	cbpe_lerp u_lx3 (.a(x_s2[0]), .b(x_s2[1]), .t(t_s2), .y(lx3));
	cbpe_lerp u_ly3 (.a(y_s2[0]), .b(y_s2[1]), .t(t_s2), .y(ly3));

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			x_s3 <= lx3;
			y_s3 <= ly3;
		end
	end

	assign point_ch.valid   = valid_s3;
	assign point_ch.point_x = x_s3;
	assign point_ch.point_y = y_s3;

endmodule
`default_nettype wire

@@ rtl/core/cbpe_lerp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbpe_lerp: one linear interpolation step
// y = a + floor((b - a) * t / 2^16), one 17x17 signed multiply.
// ----------------------------------------------------------------------------
module cbpe_lerp import cbpe_pkg::*; (
	input  coord_t  a,
	input  coord_t  b,
	input  tparam_t t,
	output coord_t  y
);

	logic signed [COORD_W:0]         diff;
	logic signed [T_W:0]             t_s;
	logic signed [COORD_W+T_W+1:0]   prod;
	logic signed [COORD_W+1:0]       sum;

	assign diff = {b[COORD_W-1], b} - {a[COORD_W-1], a};
	assign t_s  = {1'b0, t};
	assign prod = diff * t_s;
	// arithmetic shift by dropping the fraction bits floors toward minus infinity
	assign sum  = {{2{a[COORD_W-1]}}, a} + prod[COORD_W+T_W+1:T_W];
	// result stays between a and b, so the low bits are exact
	assign y    = sum[COORD_W-1:0];

endmodule
`default_nettype wire

@@ rtl/core/cbpe_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbpe_cfg_regs: control point register file
// Write-only port; indexes past the last register are dropped.
// ----------------------------------------------------------------------------
module cbpe_cfg_regs import cbpe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  reg_idx_t              cfg_idx,
	input  logic [REG_DATA_W-1:0] cfg_data,
	output ctrl_pts_t             pts
);

	ctrl_pts_t pts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_P0_X: pts_q.x[0] <= coord_t'(cfg_data);
				REG_P0_Y: pts_q.y[0] <= coord_t'(cfg_data);
				REG_P1_X: pts_q.x[1] <= coord_t'(cfg_data);
				REG_P1_Y: pts_q.y[1] <= coord_t'(cfg_data);
				REG_P2_X: pts_q.x[2] <= coord_t'(cfg_data);
				REG_P2_Y: pts_q.y[2] <= coord_t'(cfg_data);
				REG_P3_X: pts_q.x[3] <= coord_t'(cfg_data);
				REG_P3_Y: pts_q.y[3] <= coord_t'(cfg_data);
				default: ; // drop writes past the last register
			endcase
		end
	end

	assign pts = pts_q;

endmodule
`default_nettype wire
